// ===== rtl/core/sticky_masked_interrupt_controller_unit_assert.svh =====
// Assertion macros shared by the interrupt controller RTL.
// No dependencies; include after the module header.
`ifndef STICKY_MASKED_INTERRUPT_CONTROLLER_UNIT_ASSERT_SVH
`define STICKY_MASKED_INTERRUPT_CONTROLLER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Check that cond holds in the same cycle as trig.
`define SMIC_ASSERT_SAME(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("assertion failed");
// Check that cond holds in the cycle after trig.
`define SMIC_ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("assertion failed");
`else
`define SMIC_ASSERT_SAME(label, clk, rst, trig, cond)
`define SMIC_ASSERT_NEXT(label, clk, rst, trig, cond)
`endif
`endif

// ===== rtl/core/smic_pkg.sv =====
// Package for the sticky masked interrupt controller: codes, offsets, item types.
// No dependencies.
`default_nettype none
package smic_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned ADDR_W = 32;

  // Item kinds carried on s_tuser
  localparam logic [1:0] OP_SOURCE = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // Register offsets
  localparam logic [ADDR_W-1:0] OFS_PENDING = 32'h0000_0000;
  localparam logic [ADDR_W-1:0] OFS_CLEAR   = 32'h0000_0008;
  localparam logic [ADDR_W-1:0] OFS_MASK_RD = 32'h0000_0010;
  localparam logic [ADDR_W-1:0] OFS_MASK_WR = 32'h0000_0018;
  localparam logic [ADDR_W-1:0] OFS_ACK1    = 32'h0000_0020;
  localparam logic [ADDR_W-1:0] OFS_ACK2    = 32'h0000_0028;
  localparam logic [ADDR_W-1:0] OFS_ACK3    = 32'h0000_0030;
  localparam logic [ADDR_W-1:0] OFS_LIMIT   = 32'h0000_0038;

  // Bus status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_UNPERMITTED = 2'd1;
  localparam logic [1:0] ST_UNMAPPED    = 2'd2;
  localparam logic [1:0] ST_RESERVED    = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_STICKY = 2'd0;
  localparam logic [1:0] CFG_ACK1   = 2'd1;
  localparam logic [1:0] CFG_ACK2   = 2'd2;
  localparam logic [1:0] CFG_ACK3   = 2'd3;

  localparam logic [DATA_W-1:0] STICKY_RESET = 8'h07;

  typedef struct packed {
    logic [3:0]        pad;
    logic [DATA_W-1:0] write_byte;
    logic [ADDR_W-1:0] bus_address;
    logic              source_level;
    logic [2:0]        source_index;
  } in_item_t;

  typedef struct packed {
    logic [4:0]        pad;
    logic              irq_line;
    logic [1:0]        bus_status;
    logic [DATA_W-1:0] read_byte;
  } out_item_t;

endpackage
`default_nettype wire

// ===== rtl/core/sticky_masked_interrupt_controller_unit.sv =====
// A transfer accepted into the input register moves on to the result register.
// Throughput: one item per clock; the input register and the result register
// advance together whenever the result slot is empty or being taken.
// Reset (rst, synchronous): pending bits and mask clear, sticky set = 0x07,
// ack slots = 0, both pipeline slots empty.
// Depends on smic_pkg and sticky_masked_interrupt_controller_unit_assert.svh.
`default_nettype none
module sticky_masked_interrupt_controller_unit #(
  parameter int unsigned SOURCE_COUNT = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  // Input stream
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  // s_tdata: source_index[2:0], source_level[3], bus_address[35:4],
  //          write_byte[43:36], zero fill[47:44]
  input  wire logic [47:0] s_tdata,
  // s_tuser: op[1:0]
  input  wire logic [1:0]  s_tuser,
  // Result stream
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  // m_tdata: read_byte[7:0], bus_status[9:8], irq_line[10], zero fill[15:11]
  output      logic [15:0] m_tdata
);

  localparam int unsigned DW = smic_pkg::DATA_W;
  localparam logic [3:0] SRC_LIMIT = 4'(SOURCE_COUNT);

  // Configuration registers
  logic [DW-1:0] sticky_sources;
  logic [DW-1:0] ack_slot_one;
  logic [DW-1:0] ack_slot_two;
  logic [DW-1:0] ack_slot_three;

  // Architectural state
  logic [SOURCE_COUNT-1:0] pending_bits;
  logic [SOURCE_COUNT-1:0] pending_bits_next;
  logic [DW-1:0]           enable_mask;
  logic [DW-1:0]           enable_mask_next;

  // Input register
  logic                in_valid;
  logic [1:0]          in_op;
  smic_pkg::in_item_t  in_item;

  // Result register
  smic_pkg::out_item_t out_item;
  smic_pkg::out_item_t out_item_next;

  logic                    advance;
  logic                    src_ok;
  logic [SOURCE_COUNT-1:0] src_hit;
  logic [DW-1:0]           pend_wide;
  logic [1:0]              fail_status;

  // The item in the input register moves on when the result slot frees up.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tdata  = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      sticky_sources <= smic_pkg::STICKY_RESET;
      ack_slot_one   <= '0;
      ack_slot_two   <= '0;
      ack_slot_three <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        smic_pkg::CFG_STICKY: sticky_sources <= cfg_data;
        smic_pkg::CFG_ACK1:   ack_slot_one   <= cfg_data;
        smic_pkg::CFG_ACK2:   ack_slot_two   <= cfg_data;
        smic_pkg::CFG_ACK3:   ack_slot_three <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode the source event target; indexes past the source count hit nothing.
  assign src_ok = {1'b0, in_item.source_index} < SRC_LIMIT;

  always_comb begin
    for (int i = 0; i < SOURCE_COUNT; i++) begin
      src_hit[i] = src_ok && (in_item.source_index == 3'(i));
    end
  end

  always_comb begin
    pend_wide = '0;
    pend_wide[SOURCE_COUNT-1:0] = pending_bits;
  end

  assign fail_status = (in_item.bus_address < smic_pkg::OFS_LIMIT) ?
                       smic_pkg::ST_UNPERMITTED : smic_pkg::ST_UNMAPPED;

  // Single-pass update: state change and result from the held item.
  always_comb begin
    pending_bits_next        = pending_bits;
    enable_mask_next         = enable_mask;
    out_item_next            = '0;
    out_item_next.bus_status = smic_pkg::ST_OK;
    case (in_op)
      smic_pkg::OP_SOURCE: begin
        if (in_item.source_level) begin
          pending_bits_next = pending_bits | src_hit;
        end else begin
          // Sticky sources ignore the falling level
          pending_bits_next = pending_bits &
                              ~(src_hit & ~sticky_sources[SOURCE_COUNT-1:0]);
        end
      end
      smic_pkg::OP_WRITE: begin
        if (in_item.bus_address == smic_pkg::OFS_CLEAR) begin
          pending_bits_next = pending_bits & ~in_item.write_byte[SOURCE_COUNT-1:0];
        end else if (in_item.bus_address == smic_pkg::OFS_MASK_WR) begin
          enable_mask_next = in_item.write_byte;
        end else begin
          out_item_next.bus_status = fail_status;
        end
      end
      smic_pkg::OP_READ: begin
        if (in_item.bus_address == smic_pkg::OFS_PENDING) begin
          out_item_next.read_byte = pend_wide & enable_mask;
        end else if (in_item.bus_address == smic_pkg::OFS_MASK_RD) begin
          out_item_next.read_byte = enable_mask;
        end else if (in_item.bus_address == smic_pkg::OFS_ACK1) begin
          out_item_next.read_byte = ack_slot_one;
        end else if (in_item.bus_address == smic_pkg::OFS_ACK2) begin
          out_item_next.read_byte = ack_slot_two;
        end else if (in_item.bus_address == smic_pkg::OFS_ACK3) begin
          out_item_next.read_byte = ack_slot_three;
        end else begin
          out_item_next.bus_status = fail_status;
        end
      end
      default: ;
    endcase
    // irq reflects the state left behind by this item
    out_item_next.irq_line =
      |(pending_bits_next & enable_mask_next[SOURCE_COUNT-1:0]);
  end

  // Control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      m_tvalid     <= 1'b0;
      pending_bits <= '0;
      enable_mask  <= '0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        m_tvalid     <= 1'b1;
        pending_bits <= pending_bits_next;
        enable_mask  <= enable_mask_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload: hold until the next transfer
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op   <= s_tuser;
      in_item <= s_tdata;
    end
    if (advance) begin
      out_item <= out_item_next;
    end
  end

`include "sticky_masked_interrupt_controller_unit_assert.svh"

  // A waiting result always shows the irq of the current state
  `SMIC_ASSERT_SAME(a_irq_matches_state, clk, rst, m_tvalid,
    out_item.irq_line == (|(pend_wide & enable_mask)))
  // The reserved status code is never produced
  `SMIC_ASSERT_SAME(a_status_legal, clk, rst, m_tvalid,
    out_item.bus_status != smic_pkg::ST_RESERVED)
  // Input back-pressure only when both slots are full and the output stalls
  `SMIC_ASSERT_SAME(a_ready_reason, clk, rst, !s_tready,
    in_valid && m_tvalid && !m_tready)
  // An advancing item always lands in the result slot
  `SMIC_ASSERT_NEXT(a_advance_fills, clk, rst, advance, m_tvalid)

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for sticky_masked_interrupt_controller_unit.
// Drives source events and bus accesses on the input stream, predicts each result
// in-line and compares it field by field. Depends on smic_pkg and the unit RTL.
module tb_top;

  localparam int SRC_COUNT = 8;
  localparam logic [7:0] SRC_MASK = 8'((1 << SRC_COUNT) - 1);
  // op code 3 has no meaning in the block; it must return a harmless result
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // idle margin after the last result is back, before config writes
  localparam int DRAIN_CYCLES = 4;
  localparam int TAIL_CYCLES = 8;
  localparam int PHASE_ITEMS = 250;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = smic_pkg::CFG_STICKY;
  logic [7:0] cfg_data = 8'h00;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0] s_tuser = smic_pkg::OP_SOURCE;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;

  // Predicted block state and configuration
  logic [7:0] pend_bits;
  logic [7:0] en_mask;
  logic [7:0] sticky_set;
  logic [7:0] ack_val [1:3];

  smic_pkg::out_item_t awaited_results [$];
  int mismatch_count = 0;
  int burst_left = 0;

  sticky_masked_interrupt_controller_unit #(
    .SOURCE_COUNT(SRC_COUNT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Hard stop in case the block hangs on either handshake
  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Status of an access at an offset that maps to no register for that op
  function automatic logic [1:0] miss_status(input logic [31:0] addr);
    return (addr < smic_pkg::OFS_LIMIT) ? smic_pkg::ST_UNPERMITTED : smic_pkg::ST_UNMAPPED;
  endfunction

  // Apply one item to the predicted state and return the result it causes
  function automatic smic_pkg::out_item_t irq_ctrl_next(input logic [1:0] op,
                                                        input smic_pkg::in_item_t it);
    smic_pkg::out_item_t r;
    logic [7:0] src_bit;
    r = '0;
    src_bit = 8'(1) << it.source_index;
    case (op)
      smic_pkg::OP_SOURCE: begin
        if (int'(it.source_index) < SRC_COUNT) begin
          if (it.source_level)
            pend_bits = pend_bits | src_bit;
          else if ((sticky_set & src_bit) == 8'h00)
            pend_bits = pend_bits & ~src_bit;
          pend_bits = pend_bits & SRC_MASK;
        end
      end
      smic_pkg::OP_WRITE: begin
        if (it.bus_address == smic_pkg::OFS_CLEAR)
          pend_bits = pend_bits & ~it.write_byte & SRC_MASK;
        else if (it.bus_address == smic_pkg::OFS_MASK_WR)
          en_mask = it.write_byte;
        else
          r.bus_status = miss_status(it.bus_address);
      end
      smic_pkg::OP_READ: begin
        if (it.bus_address == smic_pkg::OFS_PENDING)
          r.read_byte = pend_bits & en_mask;
        else if (it.bus_address == smic_pkg::OFS_MASK_RD)
          r.read_byte = en_mask;
        else if (it.bus_address == smic_pkg::OFS_ACK1)
          r.read_byte = ack_val[smic_pkg::CFG_ACK1];
        else if (it.bus_address == smic_pkg::OFS_ACK2)
          r.read_byte = ack_val[smic_pkg::CFG_ACK2];
        else if (it.bus_address == smic_pkg::OFS_ACK3)
          r.read_byte = ack_val[smic_pkg::CFG_ACK3];
        else
          r.bus_status = miss_status(it.bus_address);
      end
      default: ;
    endcase
    r.irq_line = |(pend_bits & en_mask);
    return r;
  endfunction

  function automatic smic_pkg::in_item_t bus_item(input logic [31:0] addr,
                                                  input logic [7:0] data);
    smic_pkg::in_item_t it;
    it = '0;
    it.bus_address = addr;
    it.write_byte = data;
    return it;
  endfunction

  function automatic smic_pkg::in_item_t source_item(input logic [2:0] idx, input logic lvl);
    smic_pkg::in_item_t it;
    it = '0;
    it.source_index = idx;
    it.source_level = lvl;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Send one item; the sender runs in bursts with random gaps in between.
  // Returns in the time step of the accepting edge, with tvalid still high.
  task automatic send_item(input logic [1:0] op, input smic_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= 48'(it);
    s_tuser <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    // transfer taken at this edge: predict in acceptance order
    awaited_results.push_back(irq_ctrl_next(op, it));
  endtask

  // Drop valid and wait until every result is back and the pipeline is empty
  task automatic settle_block();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all four registers on consecutive edges; only call while idle
  task automatic write_regs(input logic [7:0] sticky, input logic [7:0] a1,
                            input logic [7:0] a2, input logic [7:0] a3);
    logic [7:0] vals [0:3];
    vals[smic_pkg::CFG_STICKY] = sticky;
    vals[smic_pkg::CFG_ACK1] = a1;
    vals[smic_pkg::CFG_ACK2] = a2;
    vals[smic_pkg::CFG_ACK3] = a3;
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    sticky_set = sticky;
    ack_val[smic_pkg::CFG_ACK1] = a1;
    ack_val[smic_pkg::CFG_ACK2] = a2;
    ack_val[smic_pkg::CFG_ACK3] = a3;
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Receiver stalls on its own schedule: always ready, a rotating 16-bit
  // pattern, or random with light or heavy back-pressure.
  int rx_mode = 0;
  int rx_left = 0;
  int rx_step = 0;
  logic [15:0] rx_pattern = 16'hffff;

  always @(posedge clk) begin
    rx_step <= rx_step + 1;
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(16, 80);
      rx_pattern <= 16'($urandom) | 16'h0101;
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= rx_pattern[rx_step % 16];
      2: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= ($urandom_range(0, 2) == 0);
    endcase
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin : result_check
    smic_pkg::out_item_t got;
    smic_pkg::out_item_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = smic_pkg::out_item_t'(m_tdata);
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none actual %h", $time, m_tdata);
      end else begin
        want = awaited_results.pop_front();
        if (got.read_byte !== want.read_byte || got.bus_status !== want.bus_status ||
            got.irq_line !== want.irq_line) begin
          mismatch_count++;
          if (got.read_byte !== want.read_byte)
            $display("%0t: read_byte expected %h actual %h",
                     $time, want.read_byte, got.read_byte);
          if (got.bus_status !== want.bus_status)
            $display("%0t: bus_status expected %0d actual %0d",
                     $time, want.bus_status, got.bus_status);
          if (got.irq_line !== want.irq_line)
            $display("%0t: irq_line expected %0d actual %0d",
                     $time, want.irq_line, got.irq_line);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset contents: nothing pending, mask clear, ack slot zero
  task automatic test_reset_values();
    send_item(smic_pkg::OP_READ, bus_item(smic_pkg::OFS_PENDING, 8'h00));
    send_item(smic_pkg::OP_READ, bus_item(smic_pkg::OFS_MASK_RD, 8'h00));
    send_item(smic_pkg::OP_READ, bus_item(smic_pkg::OFS_ACK1, 8'h00));
  endtask

  // Set and drop sources at both ends of the index range; sources 0..2 are
  // sticky after reset, so only a clear write removes them
  task automatic test_source_events();
    send_item(smic_pkg::OP_WRITE, bus_item(smic_pkg::OFS_MASK_WR, 8'hff));
    send_item(smic_pkg::OP_SOURCE, source_item(3'd7, 1'b1));
    send_item(smic_pkg::OP_SOURCE, source_item(3'd0, 1'b1));
    send_item(smic_pkg::OP_READ, bus_item(smic_pkg::OFS_PENDING, 8'h00));
    send_item(smic_pkg::OP_SOURCE, source_item(3'd0, 1'b0));
    send_item(smic_pkg::OP_SOURCE, source_item(3'd7, 1'b0));
    send_item(smic_pkg::OP_READ, bus_item(smic_pkg::OFS_PENDING, 8'h00));
    // unused op must leave state alone and report the current irq
    send_item(OP_UNUSED, bus_item(smic_pkg::OFS_CLEAR, 8'hff));
    send_item(smic_pkg::OP_WRITE, bus_item(smic_pkg::OFS_CLEAR, 8'hff));
  endtask

  // Failed accesses: wrong direction and unlisted offsets below the limit,
  // then offsets at and far beyond it
  task automatic test_bus_errors();
    send_item(smic_pkg::OP_WRITE, bus_item(smic_pkg::OFS_PENDING, 8'hff));
    send_item(smic_pkg::OP_READ, bus_item(smic_pkg::OFS_CLEAR, 8'h00));
    send_item(smic_pkg::OP_READ, bus_item(smic_pkg::OFS_LIMIT - 1, 8'h00));
    send_item(smic_pkg::OP_WRITE, bus_item(smic_pkg::OFS_LIMIT, 8'h55));
    send_item(smic_pkg::OP_READ, bus_item(32'hffff_ffff, 8'h00));
    send_item(smic_pkg::OP_WRITE, bus_item(32'h8000_0001, 8'haa));
  endtask

  // All sources sticky and extreme ack values
  task automatic test_config_extremes();
    settle_block();
    write_regs(8'hff, 8'hff, 8'h80, 8'h01);
    send_item(smic_pkg::OP_SOURCE, source_item(3'd5, 1'b1));
    send_item(smic_pkg::OP_SOURCE, source_item(3'd5, 1'b0));
    send_item(smic_pkg::OP_READ, bus_item(smic_pkg::OFS_ACK1, 8'h00));
    send_item(smic_pkg::OP_READ, bus_item(smic_pkg::OFS_ACK2, 8'h00));
    send_item(smic_pkg::OP_READ, bus_item(smic_pkg::OFS_ACK3, 8'h00));
  endtask

  // Mostly well-formed accesses at mapped offsets, with some noise below the
  // limit and some fully random addresses; unused fields carry random bits
  task automatic make_random_item(output logic [1:0] op, output smic_pkg::in_item_t it);
    int pick;
    logic [31:0] good_addr;
    it = '0;
    it.source_index = 3'($urandom_range(0, 7));
    it.source_level = 1'($urandom_range(0, 1));
    it.write_byte = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 40)
      op = smic_pkg::OP_SOURCE;
    else if (pick < 65)
      op = smic_pkg::OP_WRITE;
    else if (pick < 96)
      op = smic_pkg::OP_READ;
    else
      op = OP_UNUSED;
    if (op == smic_pkg::OP_WRITE) begin
      good_addr = ($urandom_range(0, 1) == 0) ? smic_pkg::OFS_CLEAR : smic_pkg::OFS_MASK_WR;
    end else begin
      case ($urandom_range(0, 4))
        0: good_addr = smic_pkg::OFS_PENDING;
        1: good_addr = smic_pkg::OFS_MASK_RD;
        2: good_addr = smic_pkg::OFS_ACK1;
        3: good_addr = smic_pkg::OFS_ACK2;
        default: good_addr = smic_pkg::OFS_ACK3;
      endcase
    end
    pick = $urandom_range(0, 99);
    if (pick < 80)
      it.bus_address = good_addr;
    else if (pick < 92)
      it.bus_address = 32'($urandom_range(0, 32'h37));
    else
      it.bus_address = $urandom;
  endtask

  // Random traffic in phases, changing the configuration between phases
  task automatic test_random_traffic();
    logic [1:0] op;
    smic_pkg::in_item_t it;
    for (int phase = 0; phase < 4; phase++) begin
      settle_block();
      case (phase)
        0: write_regs(8'h00, 8'h00, 8'hff, 8'h5a);
        1: write_regs(8'hff, 8'($urandom), 8'($urandom), 8'($urandom));
        default: write_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        make_random_item(op, it);
        send_item(op, it);
      end
    end
  endtask

  initial begin
    pend_bits = 8'h00;
    en_mask = 8'h00;
    sticky_set = smic_pkg::STICKY_RESET;
    ack_val[smic_pkg::CFG_ACK1] = 8'h00;
    ack_val[smic_pkg::CFG_ACK2] = 8'h00;
    ack_val[smic_pkg::CFG_ACK3] = 8'h00;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_source_events();
    test_bus_errors();
    test_config_extremes();
    test_random_traffic();

    // drain the last results, then allow a few idle edges for strays
    settle_block();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
